[hdl/bc_pkg.sv]
package bc_pkg;

  // field widths
  localparam int N_W    = 6;
  localparam int COEF_W = 59;

  // running value and its serial divider
  localparam int ACC_W  = 64;
  localparam int DVS_W  = N_W;
  localparam int REM_W  = DVS_W;
  localparam int STEP_W = $clog2(ACC_W);

  localparam logic [N_W-1:0] MAX_N = N_W'(62);

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[hdl/bc_if.sv]
interface bc_in_if;
  logic                    valid;
  logic                    ready;
  logic [bc_pkg::N_W-1:0]  n;
  logic [bc_pkg::N_W-1:0]  k;

  modport source (output valid, output n, output k, input ready);
  modport sink   (input valid, input n, input k, output ready);
endinterface

interface bc_out_if;
  logic                      valid;
  logic                      ready;
  logic [bc_pkg::COEF_W-1:0] coefficient;
  logic                      invalid;

  modport source (output valid, output coefficient, output invalid, input ready);
  modport sink   (input valid, input coefficient, input invalid, output ready);
endinterface

[hdl/bc_divider.sv]
module bc_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bc_pkg::ACC_W-1:0]   dividend,
  input  logic [bc_pkg::DVS_W-1:0]   divisor,
  output logic [bc_pkg::ACC_W-1:0]   quotient,
  output bc_pkg::div_status_t        status
);

  logic [bc_pkg::ACC_W-1:0]  dvd_r, dvd_nxt;
  logic [bc_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [bc_pkg::DVS_W-1:0]  dvs_r;
  logic [bc_pkg::STEP_W-1:0] cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic [bc_pkg::REM_W:0]    shifted;
  logic                      q_bit;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_r, dvd_r[bc_pkg::ACC_W-1]};
    q_bit   = (shifted >= {1'b0, dvs_r});
    if (q_bit) begin
      rem_nxt = bc_pkg::REM_W'(shifted - {1'b0, dvs_r});
    end else begin
      rem_nxt = shifted[bc_pkg::REM_W-1:0];
    end
    dvd_nxt = {dvd_r[bc_pkg::ACC_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == bc_pkg::STEP_W'(bc_pkg::ACC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient    = dvd_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

[hdl/binomial_coefficient.sv]
// Binomial coefficient C(n,k) for n up to 62, one request at a time. A request with
// k above n, or n above 62, returns coefficient 0 with invalid set. Otherwise k is
// first replaced by min(k, n-k) and the running value is multiplied by (n-i) and
// divided exactly by (i+1) for each i below it. Each division is done by the serial
// restoring divider, which yields one quotient bit per cycle over the 64-bit running
// value. The result waits in an output register, and the next request may be taken
// while it does.
module binomial_coefficient (
  input  logic     clk,
  input  logic     rst_n,
  bc_in_if.sink    in_ch,
  bc_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_START,
    S_WAIT,
    S_FINISH
  } state_t;

  state_t                     state_r;
  logic [bc_pkg::N_W-1:0]     n_r;
  logic [bc_pkg::N_W-1:0]     kk_r;
  logic [bc_pkg::N_W-1:0]     i_r;
  logic [bc_pkg::ACC_W-1:0]   acc_r;
  logic                       bad_r;
  logic                       out_valid_r;
  logic [bc_pkg::COEF_W-1:0]  coef_r;
  logic                       invalid_r;

  logic [bc_pkg::N_W-1:0]          n_minus_k;
  logic [bc_pkg::N_W-1:0]          factor;
  logic [bc_pkg::ACC_W+bc_pkg::N_W-1:0] prod_full;
  logic [bc_pkg::ACC_W-1:0]        prod_nxt;
  logic                            bad_nxt;
  logic [bc_pkg::N_W-1:0]          kk_nxt;
  logic [bc_pkg::ACC_W-1:0]        quotient;
  bc_pkg::div_status_t             div_status;
  logic                            div_start;

  always_comb begin
    n_minus_k = in_ch.n - in_ch.k;
    bad_nxt   = (in_ch.n > bc_pkg::MAX_N) || (in_ch.k > in_ch.n);
    kk_nxt    = (in_ch.k > n_minus_k) ? n_minus_k : in_ch.k;
    factor    = n_r - i_r;
    prod_full = acc_r * factor;
    prod_nxt  = prod_full[bc_pkg::ACC_W-1:0];
  end

  assign div_start = (state_r == S_START);

  bc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (i_r + 1'b1),
    .quotient (quotient),
    .status   (div_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // drop the held item once taken, unless a new one replaces it
      if (out_valid_r && out_ch.ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            n_r   <= in_ch.n;
            kk_r  <= kk_nxt;
            bad_r <= bad_nxt;
            i_r   <= '0;
            acc_r <= bc_pkg::ACC_W'(1);
            state_r <= bad_nxt ? S_FINISH : S_CHECK;
          end
        end
        S_CHECK: begin
          if (i_r == kk_r) begin
            state_r <= S_FINISH;
          end else begin
            acc_r   <= prod_nxt;
            state_r <= S_START;
          end
        end
        S_START: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (div_status.done) begin
            acc_r   <= quotient;
            i_r     <= i_r + 1'b1;
            state_r <= S_CHECK;
          end
        end
        S_FINISH: begin
          // hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            invalid_r   <= bad_r;
            coef_r      <= bad_r ? '0 : acc_r[bc_pkg::COEF_W-1:0];
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.coefficient = coef_r;
  assign out_ch.invalid     = invalid_r;

endmodule

[hdl/bc_checker.sv]
module bc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bc_pkg::COEF_W-1:0] coefficient,
  input logic                      invalid
);

  // an invalid item carries no coefficient
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && invalid |-> coefficient == '0)
    else $error("invalid item with non-zero coefficient");

  // every defined coefficient is at least one
  a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !invalid |-> coefficient != '0)
    else $error("valid item with zero coefficient");

  // one request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accept");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(coefficient) && $stable(invalid))
    else $error("stalled result changed");

endmodule

bind binomial_coefficient bc_checker u_bc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .coefficient (out_ch.coefficient),
  .invalid     (out_ch.invalid)
);
